// ----- rtl/cit_pkg.sv -----
// Shared types, widths and operation codes for the cheapest insertion tour unit.
`timescale 1ns / 1ps
`default_nettype none
package cit_pkg;

  // Field widths fixed by the interface
  localparam int MAX_CITIES_DEF = 32;
  localparam int CITY_W = 5;
  localparam int POS_W = 6;
  localparam int CC_W = 6;
  localparam int DIST_W = 32;
  // Signed cost d[a][c] + d[c][b] - d[a][b] spans -(2^32 - 1) .. 2^33 - 2
  localparam int COST_W = DIST_W + 2;
  localparam logic [CC_W-1:0] CC_RESET = 6'd32;

  // Input item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  // Operations of the shared cost unit
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_LOAD  = 3'd2,
    OP_ADD   = 3'd3,
    OP_EVAL  = 3'd4
  } cit_op_t;

  typedef struct packed {
    logic              mode;
    logic [4:0]        row;
    logic [4:0]        col;
    logic [DIST_W-1:0] distance;
  } cit_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [CITY_W-1:0] city;
    logic              last;
  } cit_out_t;

endpackage
`default_nettype wire

// ----- rtl/cit_dist_mem.sv -----
// Distance matrix memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cit_dist_mem
  import cit_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DIST_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DIST_W-1:0] rdata
);

  logic [DIST_W-1:0] mem [2**AW];

  // Write one entry per load beat
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/cit_link_mem.sv -----
// Tour successor memory: next city after each city in the closed tour.
`timescale 1ns / 1ps
`default_nettype none
module cit_link_mem #(
  parameter int DEPTH = 32,
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [CW-1:0] waddr,
  input  wire logic [CW-1:0] wdata,
  input  wire logic [CW-1:0] raddr,
  output logic      [CW-1:0] rdata
);

  logic [CW-1:0] mem [DEPTH];

  // Write one link
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/cit_cost_unit.sv -----
// Shared insertion cost accumulator with running minimum.
`timescale 1ns / 1ps
`default_nettype none
module cit_cost_unit
  import cit_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cit_op_t           op,
  input  wire logic [DIST_W-1:0] dist_val,
  output logic                   better
);

  logic signed [COST_W-1:0] acc;
  logic signed [COST_W-1:0] best;
  logic signed [COST_W-1:0] dext;
  logic signed [COST_W-1:0] cost;
  logic                     found;

  // Accumulate distances, and subtract the closing edge for the final cost
  assign dext = $signed({2'b00, dist_val});
  assign cost = acc - dext;
  assign better = (op == OP_EVAL) && (!found || (cost < best));

  // Accumulator and best cost
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: acc <= dext;
      OP_ADD:  acc <= acc + dext;
      default: acc <= acc;
    endcase
    if (better) begin
      best <= cost;
    end
  end

  // Track whether a candidate has been seen this round
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      case (op)
        OP_CLEAR: found <= 1'b0;
        OP_EVAL:  found <= 1'b1;
        default:  found <= found;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_eval_sets_found: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EVAL) |=> found)
    else $error("cost unit: found not set after an evaluation");
  a_clear_drops_found: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CLEAR) |=> !found)
    else $error("cost unit: found still set after a clear");
  a_best_tracks: assert property (@(posedge clk) disable iff (rst)
    better |=> (best == $past(cost)))
    else $error("cost unit: best cost not updated on a better candidate");
`endif

endmodule
`default_nettype wire

// ----- rtl/cheapest_insertion_tour_unit.sv -----
// Top level: sequencer for cheapest insertion tour build and tour readout.
`timescale 1ns / 1ps
`default_nettype none
// A load beat (mode 0) writes one Q16.16 distance entry; rows or columns at
// or above MAX_CITIES are dropped. A run beat (mode 1) builds a closed tour
// over n = city_count cities (0 read as 1, capped at MAX_CITIES) starting at
// city 0, then sends n+1 result beats: the tour in order and city 0 again
// marked last. The tour is held as a linked list of successors, and each
// candidate slot needs three reads of the distance memory's single read port,
// so checking one slot passes through ST_RD1, ST_RD2, ST_RD3 and ST_EVAL, and
// each result beat passes through ST_ORD and ST_OUT, where ST_OUT waits for
// out_ready. No item is taken while a run is in progress.
module cheapest_insertion_tour_unit
  import cit_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [CC_W-1:0] cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cit_in_t         in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cit_out_t             out_data
);

  localparam int CW = $clog2(MAX_CITIES);
  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int AW = 2 * CW;
  localparam logic [CC_W-1:0] MAX_CC = CC_W'(MAX_CITIES);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_INIT  = 13'b0000000000010,
    ST_ROUND = 13'b0000000000100,
    ST_PICK  = 13'b0000000001000,
    ST_RD1   = 13'b0000000010000,
    ST_RD2   = 13'b0000000100000,
    ST_RD3   = 13'b0000001000000,
    ST_EVAL  = 13'b0000010000000,
    ST_INS1  = 13'b0000100000000,
    ST_INS2  = 13'b0001000000000,
    ST_ORD   = 13'b0010000000000,
    ST_OUT   = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CC_W-1:0]       city_count;
  logic [NW-1:0]         n_reg;
  logic [NW-1:0]         n_sel;
  logic [NW-1:0]         len;
  logic [NW-1:0]         len_inc;
  logic [NW-1:0]         pos;
  logic [CW-1:0]         c;
  logic [CW-1:0]         a;
  logic [CW-1:0]         b_reg;
  logic [CW-1:0]         cur;
  logic [CW-1:0]         best_city;
  logic [CW-1:0]         best_a;
  logic [CW-1:0]         best_b;
  logic [MAX_CITIES-1:0] visited;
  logic                  last_c;
  logic                  in_acc;
  logic                  better;
  cit_op_t               op;

  logic              dist_we;
  logic [AW-1:0]     dist_waddr;
  logic [AW-1:0]     dist_raddr;
  logic [DIST_W-1:0] dist_rdata;
  logic              link_we;
  logic [CW-1:0]     link_waddr;
  logic [CW-1:0]     link_wdata;
  logic [CW-1:0]     link_raddr;
  logic [CW-1:0]     link_rdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CC_RESET;
    end else if (cfg_write) begin
      city_count <= cfg_data;
    end
  end

  // Effective city count
  always_comb begin
    if (city_count == '0) begin
      n_sel = NW'(1);
    end else if (city_count > MAX_CC) begin
      n_sel = NW'(MAX_CITIES);
    end else begin
      n_sel = NW'(city_count);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign last_c = (NW'(c) == (n_reg - NW'(1)));
  assign len_inc = len + NW'(1);

  // Load beats go straight to the distance memory
  assign dist_we = in_acc && (in_data.mode == MODE_LOAD)
                   && ({1'b0, in_data.row} < MAX_CC)
                   && ({1'b0, in_data.col} < MAX_CC);
  assign dist_waddr = {CW'(in_data.row), CW'(in_data.col)};

  // Steer the distance read port: d[a][c], then d[c][b], then d[a][b]
  always_comb begin
    case (state)
      ST_RD2:  dist_raddr = {c, link_rdata};
      ST_RD3:  dist_raddr = {a, b_reg};
      default: dist_raddr = {a, c};
    endcase
  end

  // Steer the link memory
  always_comb begin
    link_we = 1'b0;
    link_waddr = best_a;
    link_wdata = best_city;
    case (state)
      ST_INIT: begin
        link_we = 1'b1;
        link_waddr = '0;
        link_wdata = '0;
      end
      ST_INS1: begin
        link_we = 1'b1;
        link_waddr = best_city;
        link_wdata = best_b;
      end
      ST_INS2: begin
        link_we = 1'b1;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_ORD, ST_OUT: link_raddr = cur;
      default:        link_raddr = a;
    endcase
  end

  // Cost unit operation per state
  always_comb begin
    case (state)
      ST_ROUND: op = OP_CLEAR;
      ST_RD2:   op = OP_LOAD;
      ST_RD3:   op = OP_ADD;
      ST_EVAL:  op = OP_EVAL;
      default:  op = OP_NONE;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.mode == MODE_RUN)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: state_next = (n_reg == NW'(1)) ? ST_ORD : ST_ROUND;
      ST_ROUND: state_next = ST_PICK;
      ST_PICK: begin
        if (!visited[c]) begin
          state_next = ST_RD1;
        end else if (last_c) begin
          state_next = ST_INS1;
        end
      end
      ST_RD1: state_next = ST_RD2;
      ST_RD2: state_next = ST_RD3;
      ST_RD3: state_next = ST_EVAL;
      ST_EVAL: begin
        if (b_reg != '0) begin
          state_next = ST_RD1;
        end else if (last_c) begin
          state_next = ST_INS1;
        end else begin
          state_next = ST_PICK;
        end
      end
      ST_INS1: state_next = ST_INS2;
      ST_INS2: state_next = (len_inc == n_reg) ? ST_ORD : ST_ROUND;
      ST_ORD: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_next = (pos == n_reg) ? ST_IDLE : ST_ORD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.mode == MODE_RUN)) begin
          n_reg <= n_sel;
        end
      end
      ST_INIT: begin
        len <= NW'(1);
        cur <= '0;
        pos <= '0;
      end
      ST_ROUND: begin
        c <= CW'(1);
      end
      ST_PICK: begin
        a <= '0;
        if (visited[c] && !last_c) begin
          c <= c + CW'(1);
        end
      end
      ST_RD2: begin
        b_reg <= link_rdata;
      end
      ST_EVAL: begin
        a <= b_reg;
        if (better) begin
          best_city <= c;
          best_a <= a;
          best_b <= b_reg;
        end
        if ((b_reg == '0) && !last_c) begin
          c <= c + CW'(1);
        end
      end
      ST_INS2: begin
        len <= len_inc;
        cur <= '0;
        pos <= '0;
      end
      ST_OUT: begin
        if (out_ready) begin
          cur <= link_rdata;
          pos <= pos + NW'(1);
        end
      end
      default: begin
        a <= a;
      end
    endcase
  end

  // Visited marks: only city 0 marked at run start, set on insertion
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (state == ST_INIT) begin
      visited <= MAX_CITIES'(1);
    end else if (state == ST_INS2) begin
      visited[best_city] <= 1'b1;
    end
  end

  // Result beat
  assign out_valid = (state == ST_OUT);
  assign out_data.position = POS_W'(pos);
  assign out_data.city = CITY_W'(cur);
  assign out_data.last = (pos == n_reg);

  cit_dist_mem #(
    .AW(AW)
  ) u_dist (
    .clk  (clk),
    .we   (dist_we),
    .waddr(dist_waddr),
    .wdata(in_data.distance),
    .raddr(dist_raddr),
    .rdata(dist_rdata)
  );

  cit_link_mem #(
    .DEPTH(MAX_CITIES),
    .CW   (CW)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  cit_cost_unit u_cost (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .dist_val(dist_rdata),
    .better  (better)
  );

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos <= n_reg))
    else $error("tour unit: position beyond tour length");
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("tour unit: not ready after closing beat");
  a_start_visited: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PICK) || (state == ST_EVAL)) |-> visited[0])
    else $error("tour unit: start city not marked during build");
  a_len_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (len < n_reg))
    else $error("tour unit: round started with full tour");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the cheapest insertion tour unit.
`timescale 1ns / 1ps
module testbench;
  import cit_pkg::*;

  localparam int TOUR_MAX = MAX_CITIES_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 50;
  localparam int LONG_HOLD = 1500;
  localparam int DIRECTED_ROWS = 22;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_RUN} step_kind_t;

  // One row of the directed plan; typed_len of zero means the tour comes from the model
  typedef struct packed {
    step_kind_t      kind;
    logic [CC_W-1:0] cfg;
    logic [4:0]      row;
    logic [4:0]      col;
    logic [31:0]     entry_val;
    logic [1:0]      typed_len;
    logic [0:2][4:0] typed_tour;
  } step_t;

  logic            clk;
  logic            rst;
  logic            cfg_write;
  logic [CC_W-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  cit_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  cit_out_t        out_data;

  // Predictor state: distance matrix, which entries hold data, city count register
  logic [31:0]     dist_mem [0:TOUR_MAX-1][0:TOUR_MAX-1];
  bit              dist_known [0:TOUR_MAX-1][0:TOUR_MAX-1];
  logic [CC_W-1:0] cc_reg = CC_RESET;
  cit_out_t        pending_tour [$];

  step_t directed_plan [0:DIRECTED_ROWS-1];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int rx_hold_req = 0;
  int random_items = 0;
  int loads_sent = 0;
  int builds_sent = 0;
  int tour_beats_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  cheapest_insertion_tour_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cities in use after the register's zero and saturation rules
  function automatic int tour_cities();
    if (cc_reg == '0) return 1;
    if (cc_reg > CC_W'(TOUR_MAX)) return TOUR_MAX;
    return int'(cc_reg);
  endfunction

  // Build the cheapest insertion tour and queue its closed sequence of beats
  function automatic void plan_insertion_tour();
    int n, len, c, j, a, b, best_city, best_slot;
    longint d_ac, d_cb, d_ab, cost, best;
    bit found;
    bit on_route [0:TOUR_MAX-1];
    logic [4:0] route [0:TOUR_MAX];
    cit_out_t beat;
    n = tour_cities();
    for (c = 0; c < TOUR_MAX; c++) on_route[c] = 1'b0;
    on_route[0] = 1'b1;
    route[0] = 5'd0;
    len = 1;
    while (len < n) begin
      found = 1'b0;
      best = 0;
      best_city = 0;
      best_slot = 1;
      for (c = 0; c < n; c++) begin
        if (on_route[c]) continue;
        for (j = 0; j < len; j++) begin
          a = int'(route[j]);
          b = int'(route[(j + 1) % len]);
          d_ac = {32'd0, dist_mem[a][c]};
          d_cb = {32'd0, dist_mem[c][b]};
          d_ab = {32'd0, dist_mem[a][b]};
          cost = d_ac + d_cb - d_ab;
          // strict compare keeps the lowest city, then the earliest slot
          if (!found || cost < best) begin
            found = 1'b1;
            best = cost;
            best_city = c;
            best_slot = j + 1;
          end
        end
      end
      for (j = len; j > best_slot; j--) route[j] = route[j - 1];
      route[best_slot] = 5'(best_city);
      on_route[best_city] = 1'b1;
      len++;
    end
    route[n] = route[0];
    for (j = 0; j <= n; j++) begin
      beat.position = POS_W'(j);
      beat.city = route[j];
      beat.last = (j == n);
      pending_tour.push_back(beat);
    end
  endfunction

  // Mix of extremes, tiny values that force cost ties, whole units and full range
  function automatic logic [31:0] pick_distance();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return {30'd0, rnd[1:0]};
      5, 6: return {14'd0, rnd[1:0], 16'd0};
      default: return rnd;
    endcase
  endfunction

  function automatic cit_in_t random_load(input int n);
    cit_in_t beat;
    logic [31:0] rnd;
    rnd = $urandom;
    beat.mode = MODE_LOAD;
    if (rnd[31:29] < 3'd6) begin
      beat.row = 5'($urandom_range(0, n - 1));
      beat.col = 5'($urandom_range(0, n - 1));
    end else begin
      beat.row = rnd[4:0];
      beat.col = rnd[9:5];
    end
    beat.distance = pick_distance();
    return beat;
  endfunction

  // Run beat with junk in the fields the block ignores
  function automatic cit_in_t junk_run();
    cit_in_t beat;
    logic [31:0] rnd;
    rnd = $urandom;
    beat.mode = MODE_RUN;
    beat.row = rnd[4:0];
    beat.col = rnd[9:5];
    beat.distance = $urandom;
    return beat;
  endfunction

  // Offer one beat, hold it until accepted, then update the predictor
  task automatic send_beat(input cit_in_t beat, input bit use_model);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (beat.mode == MODE_LOAD) begin
      dist_mem[beat.row][beat.col] = beat.distance;
      dist_known[beat.row][beat.col] = 1'b1;
      loads_sent++;
    end else begin
      if (use_model) plan_insertion_tour();
      builds_sent++;
    end
  endtask

  // Write every entry a run over n cities could read that holds no data yet
  task automatic fill_square(input int n);
    cit_in_t beat;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!dist_known[r][c]) begin
          beat.mode = MODE_LOAD;
          beat.row = 5'(r);
          beat.col = 5'(c);
          beat.distance = pick_distance();
          send_beat(beat, 1'b1);
        end
      end
    end
  endtask

  // Drop valid, wait for every pending tour beat, then let the block go quiet
  task automatic settle(input int quiet);
    in_valid <= 1'b0;
    while (pending_tour.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_city_count(input logic [CC_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cc_reg = value;
    cfg_write <= 1'b0;
  endtask

  // Optional retune while idle, a few loads, then usually a tour build
  task automatic random_burst(input bit go_big);
    int n, extra;
    if (go_big || $urandom_range(0, 2) == 0) begin
      settle(SETTLE_CYCLES);
      if (go_big) write_city_count(CC_W'($urandom_range(32, 63)));
      else write_city_count(CC_W'($urandom_range(0, 9)));
    end
    n = tour_cities();
    extra = $urandom_range(0, 5);
    repeat (extra) begin
      send_beat(random_load(n), 1'b1);
      random_items++;
    end
    if ($urandom_range(0, 9) != 0) begin
      fill_square(n);
      send_beat(junk_run(), 1'b1);
      random_items++;
    end
  endtask

  function automatic void check_tour_beat(input cit_out_t got);
    cit_out_t want;
    tour_beats_seen++;
    if (pending_tour.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected tour beat: pos %0d city %0d last %0b",
                 got.position, got.city, got.last);
    end else begin
      want = pending_tour.pop_front();
      if (got.position !== want.position || got.city !== want.city ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tour beat mismatch: expected pos %0d city %0d last %0b, got %0d %0d %0b",
                   want.position, want.city, want.last, got.position, got.city, got.last);
      end
    end
  endfunction

  // Result side: check accepted beats, stall at random or hold off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready) check_tour_beat(out_data);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    cit_in_t beat;
    cit_out_t want;
    int start;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    directed_plan = '{
      '{ROW_CFG,  6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd2, {5'd0, 5'd0, 5'd0}},
      '{ROW_CFG,  6'd1,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd2, {5'd0, 5'd0, 5'd0}},
      '{ROW_LOAD, 6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd0,  5'd1,  32'hFFFF_FFFF,  2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd1,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_CFG,  6'd2,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd3, {5'd0, 5'd1, 5'd0}},
      // equal insertion costs for cities 1 and 2, then for both slots of city 2
      '{ROW_LOAD, 6'd0,  5'd0,  5'd2,  32'hFFFF_FFFF,  2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd2,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd2,  5'd1,  32'd0,          2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd1,  5'd2,  32'd0,          2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd31, 5'd31, 32'hFFFF_FFFF,  2'd0, 15'd0},
      '{ROW_CFG,  6'd3,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_LOAD, 6'd0,  5'd31, 5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_CFG,  6'd32, 5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_CFG,  6'd63, 5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0},
      '{ROW_RUN,  6'd0,  5'd0,  5'd0,  32'd0,          2'd0, 15'd0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        ROW_CFG: begin
          settle(SETTLE_CYCLES);
          write_city_count(directed_plan[i].cfg);
        end
        ROW_LOAD: begin
          beat.mode = MODE_LOAD;
          beat.row = directed_plan[i].row;
          beat.col = directed_plan[i].col;
          beat.distance = directed_plan[i].entry_val;
          send_beat(beat, 1'b1);
        end
        default: begin
          fill_square(tour_cities());
          send_beat(junk_run(), directed_plan[i].typed_len == 2'd0);
          for (int k = 0; k < int'(directed_plan[i].typed_len); k++) begin
            want.position = POS_W'(k);
            want.city = directed_plan[i].typed_tour[k];
            want.last = (k == int'(directed_plan[i].typed_len) - 1);
            pending_tour.push_back(want);
          end
        end
      endcase
    end

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      start = random_items;
      if (p == 0) begin
        // hold the result side off while loads queue up behind a build
        settle(SETTLE_CYCLES);
        write_city_count(CC_W'(8));
        fill_square(8);
        rx_hold_req = LONG_HOLD;
        send_beat(junk_run(), 1'b1);
        repeat (6) begin
          send_beat(random_load(8), 1'b1);
          random_items++;
        end
      end
      for (int burst = 0; random_items - start < PHASE_ITEMS; burst++) begin
        random_burst((p == 1 || p == 3) && burst == 0);
        if (p == 2 && $urandom_range(0, 2) == 0) settle(SETTLE_CYCLES);
      end
    end

    settle(TAIL_CYCLES);
    mismatch_count += pending_tour.size();
    $display("covered %0d load beats and %0d tour builds, %0d tour beats checked",
             loads_sent, builds_sent, tour_beats_seen);
    $display("city counts 0 to 63 under four idle mixes and a long hold, %0d cycles",
             cycle_count);
    if (mismatch_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
